FILE: hw/rtl/h264_annexb_config_ready_scan_unit_macros.svh
// assertion macros used by the annex b scan unit rtl
// no dependencies; included by files that carry concurrent checks
`ifndef H264_ANNEXB_CONFIG_READY_SCAN_UNIT_MACROS_SVH
`define H264_ANNEXB_CONFIG_READY_SCAN_UNIT_MACROS_SVH

// condition must never hold outside reset
`define AHCRS_ASSERT_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("ahcrs: forbidden condition seen");

// consequent must hold in the cycle after the antecedent
`define AHCRS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ahcrs: next-cycle check failed");

`endif

FILE: hw/rtl/ahcrs_pkg.sv
// shared types and constants of the annex b configuration-ready scan unit
// no dependencies
package ahcrs_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned NAL_TYPE_W = 5;
  localparam int unsigned RUN_W      = 2;
  localparam int unsigned OUT_TDATA_W = 8;

  localparam logic [NAL_TYPE_W-1:0] NAL_TYPE_MASK = 5'h1F;
  localparam logic [NAL_TYPE_W-1:0] NAL_TYPE_SPS  = 5'd7;
  localparam logic [NAL_TYPE_W-1:0] NAL_TYPE_PPS  = 5'd8;
  localparam logic [NAL_TYPE_W-1:0] NAL_TYPE_IDR  = 5'd5;

  localparam logic [BYTE_W-1:0] BYTE_ZERO = 8'h00;
  localparam logic [BYTE_W-1:0] BYTE_ONE  = 8'h01;

  // zero run saturates here; two zeros are enough for a start code
  localparam logic [RUN_W-1:0] ZERO_RUN_SAT = 2'd2;

  // one accepted input transaction
  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              last_byte;
    logic              key_packet;
  } scan_in_t;

  // result item, config_ready in the lowest bit
  typedef struct packed {
    logic saw_idr;
    logic saw_pps;
    logic saw_sps;
    logic config_ready;
  } result_t;

  localparam int unsigned RESULT_W = $bits(result_t);

  function automatic logic [NAL_TYPE_W-1:0] hdr_type(input logic [BYTE_W-1:0] b);
    hdr_type = b[NAL_TYPE_W-1:0] & NAL_TYPE_MASK;
  endfunction

endpackage

FILE: hw/rtl/ahcrs_scan.sv
// start code tracker and nal type flags; forms the per-packet result
// depends on ahcrs_pkg and the assertion macros
`include "h264_annexb_config_ready_scan_unit_macros.svh"

module ahcrs_scan (
  input  logic               clk,
  input  logic               rst,
  input  logic               fire,
  input  ahcrs_pkg::scan_in_t item,
  output logic               res_valid,
  output ahcrs_pkg::result_t res
);
  import ahcrs_pkg::*;

  logic [RUN_W-1:0] zero_run, zero_run_next;
  logic             header_next, header_next_next;
  logic             sps_seen, sps_seen_next;
  logic             pps_seen, pps_seen_next;
  logic             idr_seen, idr_seen_next;
  logic [NAL_TYPE_W-1:0] ntype;

  assign ntype = hdr_type(item.data_byte);

  always_comb begin
    zero_run_next    = zero_run;
    header_next_next = header_next;
    sps_seen_next    = sps_seen;
    pps_seen_next    = pps_seen;
    idr_seen_next    = idr_seen;
    if (header_next) begin
      header_next_next = 1'b0;
      zero_run_next    = '0;
      if (ntype == NAL_TYPE_SPS) begin
        sps_seen_next = 1'b1;
      end else if (ntype == NAL_TYPE_PPS) begin
        pps_seen_next = 1'b1;
      end else if (ntype == NAL_TYPE_IDR) begin
        idr_seen_next = 1'b1;
      end
    end else if (item.data_byte == BYTE_ZERO) begin
      if (zero_run != ZERO_RUN_SAT) begin
        zero_run_next = zero_run + RUN_W'(1);
      end
    end else if (item.data_byte == BYTE_ONE && zero_run == ZERO_RUN_SAT) begin
      header_next_next = 1'b1;
      zero_run_next    = '0;
    end else begin
      zero_run_next = '0;
    end
  end

  // header on the last byte is already folded into the *_next flags
  always_comb begin
    res.saw_sps      = sps_seen_next;
    res.saw_pps      = pps_seen_next;
    res.saw_idr      = idr_seen_next;
    res.config_ready = (sps_seen_next && pps_seen_next) ||
                       (item.key_packet && idr_seen_next &&
                        (sps_seen_next || pps_seen_next));
  end

  assign res_valid = fire && item.last_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      zero_run    <= '0;
      header_next <= 1'b0;
      sps_seen    <= 1'b0;
      pps_seen    <= 1'b0;
      idr_seen    <= 1'b0;
    end else if (fire) begin
      if (item.last_byte) begin
        zero_run    <= '0;
        header_next <= 1'b0;
        sps_seen    <= 1'b0;
        pps_seen    <= 1'b0;
        idr_seen    <= 1'b0;
      end else begin
        zero_run    <= zero_run_next;
        header_next <= header_next_next;
        sps_seen    <= sps_seen_next;
        pps_seen    <= pps_seen_next;
        idr_seen    <= idr_seen_next;
      end
    end
  end

  `AHCRS_ASSERT_NEVER(a_run_bounded, clk, rst, zero_run > ZERO_RUN_SAT)
  `AHCRS_ASSERT_NEVER(a_header_clears_run, clk, rst, header_next && zero_run != '0)
  `AHCRS_ASSERT_NEXT(a_packet_end_clears, clk, rst, fire && item.last_byte,
                     zero_run == '0 && !header_next && !sps_seen && !pps_seen && !idr_seen)
  `AHCRS_ASSERT_NEXT(a_header_consumed, clk, rst, fire && header_next, !header_next)

endmodule

FILE: hw/rtl/ahcrs_out_buf.sv
// two-entry output buffer that decouples result delivery from the scan
// depends on ahcrs_pkg
module ahcrs_out_buf (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  ahcrs_pkg::result_t push_data,
  output logic               can_push,
  output logic               out_valid,
  input  logic               out_ready,
  output ahcrs_pkg::result_t out_data
);
  import ahcrs_pkg::*;

  logic [1:0] count;
  result_t    slot0, slot1;
  logic       pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (count != 2'd0);
  assign can_push  = (count != 2'd2);
  assign out_data  = slot0;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else if (push && !pop) begin
      count <= count + 2'd1;
    end else if (pop && !push) begin
      count <= count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push && !pop) begin
      if (count == 2'd0) begin
        slot0 <= push_data;
      end else begin
        slot1 <= push_data;
      end
    end else if (pop && !push) begin
      slot0 <= slot1;
    end else if (pop && push) begin
      if (count == 2'd1) begin
        slot0 <= push_data;
      end else begin
        slot0 <= slot1;
        slot1 <= push_data;
      end
    end
  end

endmodule

FILE: hw/rtl/h264_annexb_config_ready_scan_unit.sv
// top level of the annex b configuration-ready scan unit
// depends on ahcrs_pkg, ahcrs_scan and ahcrs_out_buf
//
//  channel   dir  tdata                        tuser          tlast
//  s_axis    in   [7:0] data_byte              [0] key_packet last_byte
//  m_axis    out  [0] config_ready [1] saw_sps -              -
//                 [2] saw_pps [3] saw_idr, rest zero
//
// one byte per cycle unless a last byte waits on a full output buffer; each byte is held
// in the input register, is scanned there and, on the last byte, its result lands in the
// output buffer, from which it is delivered on m_axis
// rst is synchronous active high and clears zero run, header flag, nal flags and both buffers
// a stalled m_axis holds two results before back pressure reaches s_axis_tready
module h264_annexb_config_ready_scan_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,  // [7:0] data_byte
  input  logic       s_axis_tlast,  // last_byte
  input  logic [0:0] s_axis_tuser,  // [0] key_packet
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata   // [0] config_ready [1] saw_sps [2] saw_pps [3] saw_idr
);
  import ahcrs_pkg::*;

  // input register
  logic     in_valid;
  scan_in_t in_item;
  logic     fire;
  logic     s_accept;

  // scan to buffer
  logic    res_valid;
  result_t res;
  logic    can_push;
  result_t out_res;

  // a byte that carries no result never waits on the output side
  assign fire          = in_valid && (can_push || !in_item.last_byte);
  assign s_axis_tready = !in_valid || fire;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_accept) begin
      in_valid <= 1'b1;
    end else if (fire) begin
      in_valid <= 1'b0;
    end
  end

  // payload holds no reset
  always_ff @(posedge clk) begin
    if (s_accept) begin
      in_item.data_byte  <= s_axis_tdata;
      in_item.last_byte  <= s_axis_tlast;
      in_item.key_packet <= s_axis_tuser[0];
    end
  end

  ahcrs_scan u_scan (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .item      (in_item),
    .res_valid (res_valid),
    .res       (res)
  );

  ahcrs_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res),
    .can_push  (can_push),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (out_res)
  );

  // result fields from the lowest bit, upper nibble zero
  assign m_axis_tdata = {(OUT_TDATA_W - RESULT_W)'(0), out_res};

endmodule
